// ===== rtl/source_code_tokenizer_assert.svh =====
`ifndef SOURCE_CODE_TOKENIZER_ASSERT_SVH
`define SOURCE_CODE_TOKENIZER_ASSERT_SVH
// assertion helpers
`define SCT_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SCT_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/sct_pkg.sv =====
package sct_pkg;
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_line;
    logic [11:0] token_column;
    logic [11:0] token_length;
    logic [3:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  localparam logic [5:0] K_EOS = 6'd0;
  localparam logic [5:0] K_EQ = 6'd14;
  localparam logic [5:0] K_EQEQ = 6'd18;
  localparam logic [5:0] K_NE = 6'd19;
  localparam logic [5:0] K_LT = 6'd20;
  localparam logic [5:0] K_GT = 6'd22;
  localparam logic [5:0] K_INT = 6'd25;
  localparam logic [5:0] K_DOUBLE = 6'd26;
  localparam logic [5:0] K_CHAR = 6'd27;
  localparam logic [5:0] K_STRING = 6'd28;
  localparam logic [5:0] K_ID = 6'd30;
  localparam logic [5:0] K_ERROR = 6'd47;

  localparam logic [3:0] E_NONE = 4'd0;
  localparam logic [3:0] E_UNEXPECTED = 4'd1;
  localparam logic [3:0] E_BANG = 4'd2;
  localparam logic [3:0] E_CH_EMPTY = 4'd3;
  localparam logic [3:0] E_CH_EOL = 4'd4;
  localparam logic [3:0] E_CH_EOS = 4'd5;
  localparam logic [3:0] E_CH_OPEN = 4'd6;
  localparam logic [3:0] E_STR_EOL = 4'd7;
  localparam logic [3:0] E_STR_EOS = 4'd8;
  localparam logic [3:0] E_ZERO = 4'd9;
  localparam logic [3:0] E_DOT = 4'd10;

  // classified character from the front part
  typedef enum logic [3:0] {
    C_EOS, C_NL, C_WS, C_HASH, C_SINGLE, C_EQ, C_LT, C_GT, C_BANG,
    C_QUOTE, C_DQUOTE, C_ZERO, C_DIGIT, C_ALPHA, C_UNDER, C_OTHER
  } cclass_t;

  typedef struct packed {
    cclass_t    cls;
    logic [7:0] ch;
    logic [5:0] single_kind;
    logic       is_dot;
    logic       is_bslash;
  } cls_item_t;

  function automatic logic [5:0] single_kind_of(input logic [7:0] c);
    case (c)
      8'h2e: return 6'd1;
      8'h2c: return 6'd2;
      8'h28: return 6'd3;
      8'h29: return 6'd4;
      8'h5b: return 6'd5;
      8'h5d: return 6'd6;
      8'h3b: return 6'd7;
      8'h7b: return 6'd8;
      8'h7d: return 6'd9;
      8'h2b: return 6'd10;
      8'h2d: return 6'd11;
      8'h2a: return 6'd12;
      8'h2f: return 6'd13;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] kw_kind(input logic [63:0] w, input logic [3:0] len);
    logic [5:0] k;
    k = K_ID;
    case (len)
      4'd2: begin
        if (w[15:0] == "ro") k = 6'd16;
        if (w[15:0] == "fi") k = 6'd35;
      end
      4'd3: begin
        if (w[23:0] == "dna") k = 6'd15;
        if (w[23:0] == "ton") k = 6'd17;
        if (w[23:0] == "rof") k = 6'd33;
        if (w[23:0] == "wen") k = 6'd38;
        if (w[23:0] == "tni") k = 6'd40;
      end
      4'd4: begin
        if (w[31:0] == "eurt") k = 6'd24;
        if (w[31:0] == "llun") k = 6'd29;
        if (w[31:0] == "esle") k = 6'd37;
        if (w[31:0] == "rahc") k = 6'd42;
        if (w[31:0] == "loob") k = 6'd44;
        if (w[31:0] == "diov") k = 6'd45;
      end
      4'd5: begin
        if (w[39:0] == "eslaf") k = 6'd24;
        if (w[39:0] == "yarra") k = 6'd32;
        if (w[39:0] == "elihw") k = 6'd34;
        if (w[39:0] == "tsnoc") k = 6'd46;
      end
      4'd6: begin
        if (w[47:0] == "tcurts") k = 6'd31;
        if (w[47:0] == "fiesle") k = 6'd36;
        if (w[47:0] == "nruter") k = 6'd39;
        if (w[47:0] == "elbuod") k = 6'd41;
        if (w[47:0] == "gnirts") k = 6'd43;
      end
      default: k = K_ID;
    endcase
    return k;
  endfunction
endpackage

// ===== rtl/source_code_tokenizer.sv =====
// source code tokenizer
// in channel: one source byte or an end-of-stream marker per transaction
// (in_valid / in_ready, payload in_data)
// out channel: tokens with kind, line, column, length, error code and a
// last-of-run flag (out_valid / out_ready, payload out_data)
// a front stage classifies each byte into a one-entry queue; the back stage
// steps the lexer mode and counters and writes up to two tokens into an
// output buffer
// an input byte passes the queue register and then the output buffer register
// throughput: one byte per cycle while results are taken at once; a byte
// that yields two tokens holds the back stage while the second token drains
// a stalled receiver backs up the output buffer, then the queue, then in_ready
// reset: line 1, column 0, idle mode, buffers empty
// after a lexical error one error token is given and the back stage takes
// no more bytes until reset; in_ready goes low once the queue is full
module source_code_tokenizer #(
  parameter int LINE_BITS = 16,
  parameter int COLUMN_BITS = 12,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sct_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sct_pkg::out_item_t  out_data
);
  import sct_pkg::*;
`include "source_code_tokenizer_assert.svh"

  logic q_valid, q_ready, halted;
  cls_item_t q_data;

  sct_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  sct_back #(
    .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .halted(halted)
  );

  `SCT_ASSERT_IMPL(a_halt_no_take, clk, rst, halted, !q_ready)
  `SCT_ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted)
  `SCT_ASSERT_IMPL(a_err_last, clk, rst, out_valid && out_data.token_kind == K_ERROR,
    out_data.last_of_run)
endmodule

// ===== rtl/sct_front.sv =====
module sct_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sct_pkg::in_item_t    in_data,
  output logic                 q_valid,
  input  logic                 q_ready,
  output sct_pkg::cls_item_t   q_data
);
  import sct_pkg::*;

  cls_item_t c;
  logic [7:0] b;

  always_comb begin
    b = in_data.source_byte;
    c.ch = b;
    c.single_kind = single_kind_of(b);
    c.is_dot = (b == 8'h2e);
    c.is_bslash = (b == 8'h5c);
    if (in_data.end_of_stream) c.cls = C_EOS;
    else if (b == 8'h0a) c.cls = C_NL;
    else if (b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0b || b == 8'h0c)
      c.cls = C_WS;
    else if (b == 8'h23) c.cls = C_HASH;
    else if (c.single_kind != 6'd0) c.cls = C_SINGLE;
    else if (b == 8'h3d) c.cls = C_EQ;
    else if (b == 8'h3c) c.cls = C_LT;
    else if (b == 8'h3e) c.cls = C_GT;
    else if (b == 8'h21) c.cls = C_BANG;
    else if (b == 8'h27) c.cls = C_QUOTE;
    else if (b == 8'h22) c.cls = C_DQUOTE;
    else if (b == 8'h30) c.cls = C_ZERO;
    else if (b >= 8'h31 && b <= 8'h39) c.cls = C_DIGIT;
    else if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)) c.cls = C_ALPHA;
    else if (b == 8'h5f) c.cls = C_UNDER;
    else c.cls = C_OTHER;
  end

  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
    if (in_ready && in_valid) q_data <= c;
  end
endmodule

// ===== rtl/sct_back.sv =====
module sct_back #(
  parameter int LINE_BITS = 16,
  parameter int COLUMN_BITS = 12,
  parameter int KEYWORD_CHARS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sct_pkg::cls_item_t   q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sct_pkg::out_item_t   out_data,
  output logic                 halted
);
  import sct_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_EQ, M_LT, M_GT, M_BANG, M_CH_OPEN, M_CH_ESC,
    M_CH_CLOSE, M_STRING, M_ZERO, M_INT, M_DOT, M_FRAC, M_IDENT, M_HALT
  } mode_t;

  localparam logic [LINE_BITS-1:0] LMAX = '1;
  localparam logic [COLUMN_BITS-1:0] CMAX = '1;
  localparam int KWB = 8 * KEYWORD_CHARS;

  mode_t mode, mode_next;
  logic [LINE_BITS-1:0] line_cnt, line_next;
  logic [COLUMN_BITS-1:0] col, col_next, start_col, start_next, len, len_next;
  logic [KWB-1:0] kw, kw_next;

  logic [1:0] n;
  logic [1:0] n_pre;
  out_item_t r0, r1, o0, o1;
  logic has2;
  logic [COLUMN_BITS-1:0] pos;
  logic [63:0] kw64;
  logic [3:0] len4;
  cclass_t cls;
  logic fresh;
  logic [COLUMN_BITS-1:0] len_inc;

  function automatic out_item_t mk(input logic [5:0] k, input logic [LINE_BITS-1:0] ln,
                                   input logic [COLUMN_BITS-1:0] cc,
                                   input logic [COLUMN_BITS-1:0] l, input logic [3:0] e);
    out_item_t t;
    t.token_kind = k;
    t.token_line = (ln > LINE_BITS'(16'hffff)) ? 16'hffff : 16'(ln);
    t.token_column = (cc > COLUMN_BITS'(12'hfff)) ? 12'hfff : 12'(cc);
    t.token_length = (l > COLUMN_BITS'(12'hfff)) ? 12'hfff : 12'(l);
    t.error_code = e;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  // output holds two slots; accept only when empty or draining last
  logic ob_busy;
  assign q_ready = (!ob_busy || (out_ready && !has2)) && mode != M_HALT;
  assign halted = (mode == M_HALT);

  always_comb begin
    cls = q_data.cls;
    pos = (col < CMAX) ? col + 1'b1 : col;
    len_inc = (len < CMAX) ? len + 1'b1 : len;
    kw64 = 64'(kw);
    len4 = (len > COLUMN_BITS'(KEYWORD_CHARS)) ? 4'd15 : 4'(len);
    mode_next = mode;
    line_next = line_cnt;
    col_next = pos;
    start_next = start_col;
    len_next = len;
    kw_next = kw;
    n = 2'd0;
    r0 = mk(K_EOS, line_cnt, '0, '0, E_NONE);
    r1 = r0;
    fresh = 1'b0;
    n_pre = 2'd0;
    unique case (mode)
      M_COMMENT: if (cls == C_EOS || cls == C_NL) fresh = 1'b1;
      M_EQ, M_LT, M_GT: begin
        if (cls == C_EQ) begin
          n = 2'd1;
          r0 = mk(mode == M_EQ ? K_EQEQ : (mode == M_LT ? K_LT + 6'd1 : K_GT + 6'd1),
                  line_cnt, start_col, COLUMN_BITS'(2), E_NONE);
          mode_next = M_IDLE;
        end else begin
          n = 2'd1;
          r0 = mk(mode == M_EQ ? K_EQ : (mode == M_LT ? K_LT : K_GT),
                  line_cnt, start_col, COLUMN_BITS'(1), E_NONE);
          fresh = 1'b1;
        end
      end
      M_BANG: begin
        n = 2'd1;
        if (cls == C_EQ) begin
          r0 = mk(K_NE, line_cnt, start_col, COLUMN_BITS'(2), E_NONE);
          mode_next = M_IDLE;
        end else begin
          r0 = mk(K_ERROR, line_cnt, start_col, '0, E_BANG);
          mode_next = M_HALT;
        end
      end
      M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
        if (cls == C_EOS) begin
          n = 2'd1; r0 = mk(K_ERROR, line_cnt, pos, '0, E_CH_EOS); mode_next = M_HALT;
        end else if (cls == C_NL) begin
          n = 2'd1; r0 = mk(K_ERROR, line_cnt, pos, '0, E_CH_EOL); mode_next = M_HALT;
        end else if (mode == M_CH_CLOSE) begin
          n = 2'd1;
          if (cls == C_QUOTE) begin
            r0 = mk(K_CHAR, line_cnt, start_col, len, E_NONE); mode_next = M_IDLE;
          end else begin
            r0 = mk(K_ERROR, line_cnt, pos, '0, E_CH_OPEN); mode_next = M_HALT;
          end
        end else if (mode == M_CH_ESC) begin
          len_next = COLUMN_BITS'(2); mode_next = M_CH_CLOSE;
        end else if (cls == C_QUOTE) begin
          n = 2'd1; r0 = mk(K_ERROR, line_cnt, pos, '0, E_CH_EMPTY); mode_next = M_HALT;
        end else begin
          len_next = COLUMN_BITS'(1);
          mode_next = q_data.is_bslash ? M_CH_ESC : M_CH_CLOSE;
        end
      end
      M_STRING: begin
        if (cls == C_EOS) begin
          n = 2'd1; r0 = mk(K_ERROR, line_cnt, pos, '0, E_STR_EOS); mode_next = M_HALT;
        end else if (cls == C_NL) begin
          n = 2'd1; r0 = mk(K_ERROR, line_cnt, pos, '0, E_STR_EOL); mode_next = M_HALT;
        end else if (cls == C_DQUOTE) begin
          n = 2'd1; r0 = mk(K_STRING, line_cnt, start_col, len, E_NONE); mode_next = M_IDLE;
        end else len_next = len_inc;
      end
      M_ZERO, M_INT: begin
        if (cls == C_ZERO || cls == C_DIGIT) begin
          if (mode == M_ZERO) begin
            n = 2'd1; r0 = mk(K_ERROR, line_cnt, start_col, '0, E_ZERO); mode_next = M_HALT;
          end else len_next = len_inc;
        end else if (cls == C_SINGLE && q_data.is_dot) begin
          len_next = len_inc; mode_next = M_DOT;
        end else begin
          n = 2'd1; r0 = mk(K_INT, line_cnt, start_col, len, E_NONE); fresh = 1'b1;
        end
      end
      M_DOT: begin
        if (cls == C_ZERO || cls == C_DIGIT) begin
          len_next = len_inc; mode_next = M_FRAC;
        end else begin
          n = 2'd1; r0 = mk(K_ERROR, line_cnt, pos, '0, E_DOT); mode_next = M_HALT;
        end
      end
      M_FRAC: begin
        if (cls == C_ZERO || cls == C_DIGIT) len_next = len_inc;
        else begin
          n = 2'd1; r0 = mk(K_DOUBLE, line_cnt, start_col, len, E_NONE); fresh = 1'b1;
        end
      end
      M_IDENT: begin
        if (cls == C_ALPHA || cls == C_ZERO || cls == C_DIGIT || cls == C_UNDER) begin
          for (int i = 0; i < KEYWORD_CHARS; i++)
            if (len == COLUMN_BITS'(i)) kw_next[8*i +: 8] = q_data.ch;
          len_next = len_inc;
        end else begin
          n = 2'd1;
          r0 = mk(kw_kind(kw64, len4), line_cnt, start_col, len, E_NONE);
          fresh = 1'b1;
        end
      end
      M_HALT: mode_next = M_HALT;
      default: fresh = 1'b1;
    endcase

    if (fresh) begin
      n_pre = n;
      mode_next = M_IDLE;
      r1 = mk(K_EOS, line_cnt, pos, '0, E_NONE);
      unique case (cls)
        C_EOS: begin
          r1 = mk(K_EOS, line_cnt, pos, '0, E_NONE); n = n + 2'd1;
        end
        C_NL: begin
          if (line_cnt < LMAX) line_next = line_cnt + 1'b1;
          col_next = '0;
        end
        C_WS: mode_next = M_IDLE;
        C_HASH: mode_next = M_COMMENT;
        C_SINGLE: begin
          r1 = mk(q_data.single_kind, line_cnt, pos, COLUMN_BITS'(1), E_NONE);
          n = n + 2'd1;
        end
        C_EQ: begin mode_next = M_EQ; start_next = pos; len_next = COLUMN_BITS'(1); end
        C_LT: begin mode_next = M_LT; start_next = pos; len_next = COLUMN_BITS'(1); end
        C_GT: begin mode_next = M_GT; start_next = pos; len_next = COLUMN_BITS'(1); end
        C_BANG: begin mode_next = M_BANG; start_next = pos; len_next = COLUMN_BITS'(1); end
        C_QUOTE: begin mode_next = M_CH_OPEN; start_next = pos; len_next = '0; end
        C_DQUOTE: begin mode_next = M_STRING; start_next = pos; len_next = '0; end
        C_ZERO: begin mode_next = M_ZERO; start_next = pos; len_next = COLUMN_BITS'(1); end
        C_DIGIT: begin mode_next = M_INT; start_next = pos; len_next = COLUMN_BITS'(1); end
        C_ALPHA: begin
          mode_next = M_IDENT; start_next = pos; len_next = COLUMN_BITS'(1);
          kw_next = KWB'(q_data.ch);
        end
        default: begin
          r1 = mk(K_ERROR, line_cnt, pos, '0, E_UNEXPECTED);
          n = n + 2'd1;
          mode_next = M_HALT;
        end
      endcase
      if (n_pre == 2'd0 && n == 2'd1) r0 = r1;
    end
    o0 = r0;
    o1 = r1;
    if (n == 2'd1) o0.last_of_run = 1'b1;
    o1.last_of_run = 1'b1;
  end

  logic do_step;
  assign do_step = q_valid && q_ready;
  out_item_t second;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      line_cnt <= LINE_BITS'(1);
      col <= '0;
      start_col <= '0;
      len <= '0;
      kw <= '0;
      ob_busy <= 1'b0;
      has2 <= 1'b0;
    end else begin
      if (do_step && n != 2'd0) begin
        ob_busy <= 1'b1;
        has2 <= (n == 2'd2);
      end else if (out_valid && out_ready) begin
        if (has2) has2 <= 1'b0;
        else ob_busy <= 1'b0;
      end
      if (do_step) begin
        mode <= mode_next;
        line_cnt <= line_next;
        col <= col_next;
        start_col <= start_next;
        len <= len_next;
        kw <= kw_next;
      end
    end
    if (do_step && n != 2'd0) begin
      out_data <= o0;
      second <= o1;
    end else if (out_valid && out_ready && has2) begin
      out_data <= second;
    end
  end

  assign out_valid = ob_busy;
endmodule

// ===== tb/tb_checker.sv =====
module tb_checker
  import sct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COL_MAX = 4095;
  localparam int unsigned LINE_MAX = 65535;
  localparam int unsigned KW_CHARS = 6;

  localparam logic [5:0] K_DOT = 6'd1;
  localparam logic [5:0] K_COMMA = 6'd2;
  localparam logic [5:0] K_LPAREN = 6'd3;
  localparam logic [5:0] K_RPAREN = 6'd4;
  localparam logic [5:0] K_LBRACK = 6'd5;
  localparam logic [5:0] K_RBRACK = 6'd6;
  localparam logic [5:0] K_SEMI = 6'd7;
  localparam logic [5:0] K_LBRACE = 6'd8;
  localparam logic [5:0] K_RBRACE = 6'd9;
  localparam logic [5:0] K_PLUS = 6'd10;
  localparam logic [5:0] K_MINUS = 6'd11;
  localparam logic [5:0] K_STAR = 6'd12;
  localparam logic [5:0] K_SLASH = 6'd13;
  localparam logic [5:0] K_AND = 6'd15;
  localparam logic [5:0] K_OR = 6'd16;
  localparam logic [5:0] K_NOT = 6'd17;
  localparam logic [5:0] K_LE = 6'd21;
  localparam logic [5:0] K_GE = 6'd23;
  localparam logic [5:0] K_BOOL_LIT = 6'd24;
  localparam logic [5:0] K_NULL = 6'd29;
  localparam logic [5:0] K_STRUCT = 6'd31;
  localparam logic [5:0] K_ARRAY = 6'd32;
  localparam logic [5:0] K_FOR = 6'd33;
  localparam logic [5:0] K_WHILE = 6'd34;
  localparam logic [5:0] K_IF = 6'd35;
  localparam logic [5:0] K_ELSEIF = 6'd36;
  localparam logic [5:0] K_ELSE = 6'd37;
  localparam logic [5:0] K_NEW = 6'd38;
  localparam logic [5:0] K_RETURN = 6'd39;
  localparam logic [5:0] K_INT_T = 6'd40;
  localparam logic [5:0] K_DOUBLE_T = 6'd41;
  localparam logic [5:0] K_CHAR_T = 6'd42;
  localparam logic [5:0] K_STRING_T = 6'd43;
  localparam logic [5:0] K_BOOL_T = 6'd44;
  localparam logic [5:0] K_VOID_T = 6'd45;
  localparam logic [5:0] K_CONST = 6'd46;

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_EQ, M_LT, M_GT, M_BANG, M_CH_OPEN, M_CH_ESC,
    M_CH_CLOSE, M_STRING, M_ZERO, M_INT, M_DOT, M_FRAC, M_IDENT, M_HALT
  } lex_mode_t;

  lex_mode_t   mode;
  int unsigned line_cnt, col_cnt, tok_start, tok_len;
  string       word;
  out_item_t   step_res[2];
  int          step_n;
  out_item_t   token_q[$];

  assign pending = token_q.size();

  function automatic logic [5:0] op_kind(logic [7:0] c);
    case (c)
      ".": return K_DOT;
      ",": return K_COMMA;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      ";": return K_SEMI;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      "+": return K_PLUS;
      "-": return K_MINUS;
      "*": return K_STAR;
      "/": return K_SLASH;
      default: return K_EOS;
    endcase
  endfunction

  function automatic logic [5:0] word_kind();
    if (tok_len > KW_CHARS) return K_ID;
    case (word)
      "and": return K_AND;
      "or": return K_OR;
      "not": return K_NOT;
      "true", "false": return K_BOOL_LIT;
      "null": return K_NULL;
      "struct": return K_STRUCT;
      "array": return K_ARRAY;
      "for": return K_FOR;
      "while": return K_WHILE;
      "if": return K_IF;
      "elseif": return K_ELSEIF;
      "else": return K_ELSE;
      "new": return K_NEW;
      "return": return K_RETURN;
      "int": return K_INT_T;
      "double": return K_DOUBLE_T;
      "char": return K_CHAR_T;
      "string": return K_STRING_T;
      "bool": return K_BOOL_T;
      "void": return K_VOID_T;
      "const": return K_CONST;
      default: return K_ID;
    endcase
  endfunction

  function void emit(logic [5:0] k, int unsigned col, int unsigned len, logic [3:0] err);
    out_item_t t;
    t.token_kind = k;
    t.token_line = line_cnt[15:0];
    t.token_column = (col > COL_MAX) ? 12'hfff : col[11:0];
    t.token_length = (len > COL_MAX) ? 12'hfff : len[11:0];
    t.error_code = err;
    t.last_of_run = 1'b0;
    step_res[step_n] = t;
    step_n++;
  endfunction

  function void lex_error(int unsigned col, logic [3:0] err);
    emit(K_ERROR, col, 0, err);
    mode = M_HALT;
  endfunction

  function void grow();
    if (tok_len < COL_MAX) tok_len++;
  endfunction

  function void open_token(lex_mode_t m, int unsigned pos, int unsigned len);
    mode = m;
    tok_start = pos;
    tok_len = len;
  endfunction

  function void lex_fresh(logic [7:0] c, logic e, int unsigned pos);
    mode = M_IDLE;
    if (e) begin
      emit(K_EOS, pos, 0, E_NONE);
    end else if (c == "\n") begin
      if (line_cnt < LINE_MAX) line_cnt++;
      col_cnt = 0;
    end else if (c == " " || c == "\t" || c == "\r" || c == "\v" || c == "\f") begin
    end else if (c == "#") begin
      mode = M_COMMENT;
    end else if (op_kind(c) != K_EOS) begin
      emit(op_kind(c), pos, 1, E_NONE);
    end else if (c == "=") begin
      open_token(M_EQ, pos, 1);
    end else if (c == "<") begin
      open_token(M_LT, pos, 1);
    end else if (c == ">") begin
      open_token(M_GT, pos, 1);
    end else if (c == "!") begin
      open_token(M_BANG, pos, 1);
    end else if (c == "'") begin
      open_token(M_CH_OPEN, pos, 0);
    end else if (c == "\"") begin
      open_token(M_STRING, pos, 0);
    end else if (c >= "0" && c <= "9") begin
      open_token((c == "0") ? M_ZERO : M_INT, pos, 1);
    end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      open_token(M_IDENT, pos, 1);
      word = $sformatf("%c", c);
    end else begin
      lex_error(pos, E_UNEXPECTED);
    end
  endfunction

  function void lex_step(logic [7:0] c, logic e);
    int unsigned pos;
    logic dig, alnum;
    step_n = 0;
    if (mode == M_HALT) return;
    dig = !e && c >= "0" && c <= "9";
    alnum = !e && (dig || c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
    if (col_cnt < COL_MAX) col_cnt++;
    pos = col_cnt;
    case (mode)
      M_COMMENT: if (e || c == "\n") lex_fresh(c, e, pos);
      M_EQ, M_LT, M_GT: begin
        if (!e && c == "=") begin
          emit((mode == M_EQ) ? K_EQEQ : (mode == M_LT) ? K_LE : K_GE, tok_start, 2, E_NONE);
          mode = M_IDLE;
        end else begin
          emit((mode == M_EQ) ? K_EQ : (mode == M_LT) ? K_LT : K_GT, tok_start, 1, E_NONE);
          lex_fresh(c, e, pos);
        end
      end
      M_BANG: begin
        if (!e && c == "=") begin
          emit(K_NE, tok_start, 2, E_NONE);
          mode = M_IDLE;
        end else lex_error(tok_start, E_BANG);
      end
      M_CH_OPEN, M_CH_ESC, M_CH_CLOSE: begin
        if (e) lex_error(pos, E_CH_EOS);
        else if (c == "\n") lex_error(pos, E_CH_EOL);
        else if (mode == M_CH_CLOSE) begin
          if (c == "'") begin
            emit(K_CHAR, tok_start, tok_len, E_NONE);
            mode = M_IDLE;
          end else lex_error(pos, E_CH_OPEN);
        end else if (mode == M_CH_ESC) begin
          tok_len = 2;
          mode = M_CH_CLOSE;
        end else if (c == "'") lex_error(pos, E_CH_EMPTY);
        else begin
          tok_len = 1;
          mode = (c == "\\") ? M_CH_ESC : M_CH_CLOSE;
        end
      end
      M_STRING: begin
        if (e) lex_error(pos, E_STR_EOS);
        else if (c == "\n") lex_error(pos, E_STR_EOL);
        else if (c == "\"") begin
          emit(K_STRING, tok_start, tok_len, E_NONE);
          mode = M_IDLE;
        end else grow();
      end
      M_ZERO, M_INT: begin
        if (dig) begin
          if (mode == M_ZERO) lex_error(tok_start, E_ZERO);
          else grow();
        end else if (!e && c == ".") begin
          grow();
          mode = M_DOT;
        end else begin
          emit(K_INT, tok_start, tok_len, E_NONE);
          lex_fresh(c, e, pos);
        end
      end
      M_DOT: begin
        if (dig) begin
          grow();
          mode = M_FRAC;
        end else lex_error(pos, E_DOT);
      end
      M_FRAC: begin
        if (dig) grow();
        else begin
          emit(K_DOUBLE, tok_start, tok_len, E_NONE);
          lex_fresh(c, e, pos);
        end
      end
      M_IDENT: begin
        if (alnum) begin
          if (tok_len < KW_CHARS) word = $sformatf("%s%c", word, c);
          grow();
        end else begin
          emit(word_kind(), tok_start, tok_len, E_NONE);
          lex_fresh(c, e, pos);
        end
      end
      default: lex_fresh(c, e, pos);
    endcase
    if (step_n > 0) step_res[step_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_res[i]);
  endfunction

  always @(posedge clk) begin
    out_item_t exp_tok;
    if (rst) begin
      mode = M_IDLE;
      line_cnt = 1;
      col_cnt = 0;
      tok_start = 0;
      tok_len = 0;
      word = "";
      token_q.delete();
      errors <= 0;
    end else begin
      if (in_valid && in_ready) lex_step(in_data.source_byte, in_data.end_of_stream);
      if (out_valid && out_ready) begin
        if (token_q.size() == 0) begin
          $error("token with no transaction to cause it: kind %0d", out_data.token_kind);
          errors <= errors + 1;
        end else begin
          exp_tok = token_q.pop_front();
          if (exp_tok != out_data) begin
            errors <= errors + 1;
            if (exp_tok.token_kind != out_data.token_kind)
              $error("token_kind exp %0d got %0d", exp_tok.token_kind, out_data.token_kind);
            if (exp_tok.token_line != out_data.token_line)
              $error("token_line exp %0d got %0d", exp_tok.token_line, out_data.token_line);
            if (exp_tok.token_column != out_data.token_column)
              $error("token_column exp %0d got %0d", exp_tok.token_column,
                     out_data.token_column);
            if (exp_tok.token_length != out_data.token_length)
              $error("token_length exp %0d got %0d", exp_tok.token_length,
                     out_data.token_length);
            if (exp_tok.error_code != out_data.error_code)
              $error("error_code exp %0d got %0d", exp_tok.error_code, out_data.error_code);
            if (exp_tok.last_of_run != out_data.last_of_run)
              $error("last_of_run exp %0d got %0d", exp_tok.last_of_run,
                     out_data.last_of_run);
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import sct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic      clk, rst;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_data;
  out_item_t out_data;
  int        errors, pending;
  int        idle_cycles;
  in_item_t  src_q[$];

  source_code_tokenizer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  tb_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function void add_byte(logic [7:0] c);
    src_q.push_back('{source_byte: c, end_of_stream: 1'b0});
  endfunction

  function void add_eos();
    src_q.push_back('{source_byte: 8'($urandom_range(0, 255)), end_of_stream: 1'b1});
  endfunction

  function void add_text(string s);
    foreach (s[i]) add_byte(s[i]);
  endfunction

  // any byte except the ones listed
  function automatic logic [7:0] pick_byte(logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x0 || c == x1 || c == x2);
    return c;
  endfunction

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function void add_digits(int n, bit lead_zero_ok);
    add_byte(lead_zero_ok ? pick_from("0123456789") : pick_from("123456789"));
    for (int i = 1; i < n; i++) add_byte(pick_from("0123456789"));
  endfunction

  function void add_number(bit frac);
    if ($urandom_range(0, 3) == 0) add_byte("0");
    else add_digits($urandom_range(1, 6), 1'b0);
    if (frac) begin
      add_byte(".");
      add_digits($urandom_range(1, 5), 1'b1);
    end
  endfunction

  // one well-formed lexeme with random content
  function void add_lexeme();
    string words[] = '{"and", "or", "not", "true", "false", "null", "struct", "array",
                       "for", "while", "if", "elseif", "else", "new", "return", "int",
                       "double", "char", "string", "bool", "void", "const", "elsei",
                       "iff", "returns", "structure", "Else", "new_1"};
    string ops[] = '{"==", "!=", "<=", ">=", "=", "<", ">"};
    int n;
    case ($urandom_range(0, 10))
      0: add_byte(pick_from(".,()[];{}+-*/"));
      1: add_text(ops[$urandom_range(0, ops.size() - 1)]);
      2: begin
        add_byte("'");
        if ($urandom_range(0, 3) == 0) begin
          add_byte("\\");
          add_byte(pick_byte("\n", "\n", "\n"));
        end else add_byte(pick_byte("'", "\n", "\\"));
        add_byte("'");
      end
      3: begin
        add_byte("\"");
        n = $urandom_range(0, 12);
        repeat (n) add_byte(pick_byte("\"", "\n", "\n"));
        add_byte("\"");
      end
      4: add_number(1'b0);
      5: add_number(1'b1);
      6: begin
        add_byte(pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        n = $urandom_range(0, 9);
        repeat (n) add_byte(pick_from("abcdefghijklmnopqrstuvwxyzXYZ0123456789_"));
      end
      7, 8: add_text(words[$urandom_range(0, words.size() - 1)]);
      9: begin
        add_byte("#");
        n = $urandom_range(0, 15);
        repeat (n) add_byte(pick_byte("\n", "\n", "\n"));
        add_byte("\n");
      end
      default: add_eos();
    endcase
  endfunction

  // separator that closes any token in progress without starting a new one
  function void add_gap();
    case ($urandom_range(0, 9))
      0, 1, 2: add_byte(" ");
      3: add_byte(pick_from("\t\r\v\f"));
      4, 5: add_byte("\n");
      6, 7: add_byte(pick_from("(),;[]{}+-*/"));
      8: add_eos();
      default: begin
        add_text(" # note ");
        add_byte(8'($urandom_range(128, 255)));
        add_byte("\n");
      end
    endcase
  endfunction

  function void build_directed();
    add_text(". , ( ) [ ] ; { } + - * / = == != < <= > >= a(b)<(x>=y)==z\n");
    add_text("and or not true false null struct array for while if elseif else new\n");
    add_text("return int double char string bool void const elseiff ifx x_9Z\n");
    add_text("0 0.0 9 1234567890 98.76 0.5 'a' '\\'' '\\n' ");
    add_byte("'"); add_byte(8'hff); add_byte("'"); add_byte(" ");
    add_byte("\""); add_byte(8'h00); add_byte(8'h80); add_byte(8'h7f); add_byte("\"");
    add_text(" \"\" # comment\n");
    add_text("id"); add_eos(); add_text("<"); add_eos(); add_text("7"); add_eos();
    add_text("3.25"); add_eos(); add_eos();
  endfunction

  function void build_error_tail();
    add_text(" ");
    case ($urandom_range(int'(E_UNEXPECTED), int'(E_DOT)))
      E_UNEXPECTED: add_byte(pick_from("_@$%^&`~|?:\\"));
      E_BANG: add_text("!a");
      E_CH_EMPTY: add_text("''");
      E_CH_EOL: add_text("'\n");
      E_CH_EOS: begin add_text("'"); add_eos(); end
      E_CH_OPEN: add_text("'ab");
      E_STR_EOL: add_text("\"ab\n");
      E_STR_EOS: begin add_text("\"ab"); add_eos(); end
      E_ZERO: add_text("01");
      default: add_text("1.x");
    endcase
  endfunction

  // sender
  initial begin
    int burst_left, gap;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    build_directed();
    while (src_q.size() < 1400) begin
      add_lexeme();
      add_gap();
    end
    add_text("last_line 42 ");
    build_error_tail();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    burst_left = 0;
    foreach (src_q[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 60);
      end
      in_valid <= 1'b1;
      in_data <= src_q[i];
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("source_code_tokenizer regression: pass");
    else $display("source_code_tokenizer regression: fail");
    $finish;
  end

  // receiver
  initial begin
    int cyc, pct;
    out_ready = 1'b0;
    cyc = 0;
    pct = 100;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 100) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (cyc % 300 == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 80;
          2: pct = 50;
          default: pct = 20;
        endcase
      end
      out_ready <= ($urandom_range(0, 99) < pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("source_code_tokenizer regression: fail");
      $finish;
    end
  end
endmodule
